/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, switched off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check across reset failed");

`endif

/* hw/rtl/ipr_pkg.sv */
`default_nettype none
package ipr_pkg;
  localparam int SCALE_W = 7;
  localparam int WIDTH_W = 13;
  localparam int CFG_W   = 13;
  localparam int PIX_W   = 24;

  localparam logic CFG_SCALE    = 1'b0;
  localparam logic CFG_IN_WIDTH = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef logic [7:0]       channel_t;
  typedef logic [PIX_W-1:0] pixel_t;
endpackage
`default_nettype wire

/* hw/rtl/ipr_if.sv */
`default_nettype none
interface ipr_in_if;
  import ipr_pkg::*;
  logic     valid;
  logic     ready;
  logic     kind;
  channel_t red_in;
  channel_t green_in;
  channel_t blue_in;

  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface ipr_out_if;
  import ipr_pkg::*;
  logic       valid;
  logic       ready;
  channel_t   red_out;
  channel_t   green_out;
  channel_t   blue_out;
  logic       row_end;
  logic [1:0] pad_count;
  logic       run_last;
  logic       error;

  modport source (output valid, red_out, green_out, blue_out, row_end, pad_count,
                  run_last, error, input ready);
  modport sink (input valid, red_out, green_out, blue_out, row_end, pad_count,
                run_last, error, output ready);
endinterface
`default_nettype wire

/* hw/rtl/integer_pixel_replication_scaler.sv */
// Integer pixel-replication upscaler for a 24-bit RGB raster.
// pix_in takes one word per item: kind 0 carries a new pixel, kind 1 is a
// replay tick. Each pixel is stored in the line memory and sent on pix_out
// scale times; after a full input row, (scale-1)*in_width ticks each send
// scale copies of the next stored pixel. A tick with nothing pending gives
// no word. A pixel taken while replays are pending gives one error word.
// The last copy of a row carries row_end and the pad byte count.
// The user must write the configuration port (cfg_we, cfg_index, cfg_data)
// only while the block is idle; the block itself does not enforce this.
// The first word of an item passes the middle stage, which holds the line
// memory read, and then the output register, which drives pix_out.
// Each item in the output register sends its copies, one word a cycle
// while pix_out is ready, while the next item waits in the middle stage.
// Reset clears the column counters, the replay count and both pipeline
// stages, and sets scale and in_width to 1; the line memory is not cleared.
// When pix_out stalls, the output word holds and pix_in stops after one
// further item has been taken into the middle stage.
`default_nettype none
module integer_pixel_replication_scaler #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [ipr_pkg::CFG_W-1:0] cfg_data,
  ipr_in_if.sink                       pix_in,
  ipr_out_if.source                    pix_out
);
  import ipr_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int CMP_W = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;

  logic [SCALE_W-1:0] scale;
  logic [WIDTH_W-1:0] in_width;
  logic [SCALE_W-1:0] s_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [1:0]         pad;

  logic [CW-1:0] write_column;
  logic [RW-1:0] replay_rows_left;
  logic [CW-1:0] replay_column;

  pixel_t line_store [MAX_WIDTH];
  pixel_t rd_data;

  logic               s1_valid;
  logic               s1_err;
  logic               s1_from_mem;
  pixel_t             s1_pix;
  logic               s1_last_col;
  logic [SCALE_W-1:0] s1_scale;
  logic [1:0]         s1_pad;

  logic               e_valid;
  logic               e_err;
  pixel_t             e_pix;
  logic [SCALE_W-1:0] e_cnt;
  logic               e_last_col;
  logic [1:0]         e_pad;

  logic          acc;
  logic          is_pixel;
  logic          pending;
  logic          drop;
  logic          mem_we;
  logic          mem_re;
  logic [CW-1:0] col_sel;
  logic          last_col;
  logic          e_last;
  logic          e_done;
  logic          e_load;
  pixel_t        in_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale    <= SCALE_W'(1);
      in_width <= WIDTH_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:    scale    <= cfg_data[SCALE_W-1:0];
        CFG_IN_WIDTH: in_width <= cfg_data[WIDTH_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    if (scale == '0) begin
      s_eff = SCALE_W'(1);
    end else if (32'(scale) > MAX_SCALE) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale;
    end
    if (in_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (32'(in_width) > MAX_WIDTH) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = in_width;
    end
  end

  assign pad = 2'(s_eff[1:0] * w_eff[1:0]);

  assign e_last = (e_cnt == SCALE_W'(1));
  assign e_done = e_valid && pix_out.ready && e_last;
  assign e_load = s1_valid && (!e_valid || e_done);

  assign pix_in.ready = !s1_valid || e_load;
  assign acc          = pix_in.valid && pix_in.ready;
  assign is_pixel     = (pix_in.kind == KIND_PIXEL);
  assign pending      = (replay_rows_left != '0);
  assign drop         = acc && is_pixel && pending;
  assign mem_we       = acc && is_pixel && !pending;
  assign mem_re       = acc && !is_pixel && pending;
  assign col_sel      = is_pixel ? write_column : replay_column;
  assign last_col     = (CMP_W'(col_sel) + CMP_W'(1)) >= CMP_W'(w_eff);
  assign in_pix       = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[write_column] <= in_pix;
    end
    if (mem_re) begin
      rd_data <= line_store[replay_column];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_column     <= '0;
      replay_rows_left <= '0;
      replay_column    <= '0;
    end else if (mem_we) begin
      if (last_col) begin
        write_column     <= '0;
        replay_rows_left <= RW'(s_eff - SCALE_W'(1));
        replay_column    <= '0;
      end else begin
        write_column <= CW'(CMP_W'(write_column) + CMP_W'(1));
      end
    end else if (mem_re) begin
      if (last_col) begin
        replay_column    <= '0;
        replay_rows_left <= replay_rows_left - RW'(1);
      end else begin
        replay_column <= CW'(CMP_W'(replay_column) + CMP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= drop || mem_we || mem_re;
    end else if (e_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_err      <= drop;
      s1_from_mem <= mem_re;
      s1_pix      <= drop ? '0 : in_pix;
      s1_last_col <= !drop && last_col;
      s1_scale    <= drop ? SCALE_W'(1) : s_eff;
      s1_pad      <= pad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_load) begin
      e_valid <= 1'b1;
    end else if (e_done) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_load) begin
      e_err      <= s1_err;
      e_pix      <= s1_from_mem ? rd_data : s1_pix;
      e_cnt      <= s1_scale;
      e_last_col <= s1_last_col;
      e_pad      <= s1_pad;
    end else if (e_valid && pix_out.ready) begin
      e_cnt <= e_cnt - SCALE_W'(1);
    end
  end

  assign pix_out.valid     = e_valid;
  assign pix_out.red_out   = e_pix[23:16];
  assign pix_out.green_out = e_pix[15:8];
  assign pix_out.blue_out  = e_pix[7:0];
  assign pix_out.row_end   = e_last_col && e_last;
  assign pix_out.pad_count = (e_last_col && e_last) ? e_pad : 2'b00;
  assign pix_out.run_last  = e_last;
  assign pix_out.error     = e_err;
endmodule
`default_nettype wire

/* hw/rtl/ipr_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module ipr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] red_out,
  input wire logic [7:0] green_out,
  input wire logic [7:0] blue_out,
  input wire logic       row_end,
  input wire logic [1:0] pad_count,
  input wire logic       run_last,
  input wire logic       error
);
  `ASSERT_NEXT_ALWAYS(a_quiet_after_reset, clk, rst, !out_valid)
  `ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready,
    out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(row_end))
  `ASSERT_IMPLY(a_error_word, clk, rst, out_valid && error,
    run_last && !row_end && pad_count == 2'b00 && red_out == 8'h00)
  `ASSERT_IMPLY(a_row_end_closes_run, clk, rst, out_valid && row_end, run_last)
  `ASSERT_IMPLY(a_pad_only_at_row_end, clk, rst, out_valid && !row_end, pad_count == 2'b00)
endmodule

bind integer_pixel_replication_scaler ipr_checker u_ipr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red_out   (pix_out.red_out),
  .green_out (pix_out.green_out),
  .blue_out  (pix_out.blue_out),
  .row_end   (pix_out.row_end),
  .pad_count (pix_out.pad_count),
  .run_last  (pix_out.run_last),
  .error     (pix_out.error)
);
`default_nettype wire
